[hdl/mah_pkg.sv]
// Shared widths, types, register codes and the CORDIC angle table.
package mah_pkg;

    // Field and datapath widths
    localparam int RAW_W       = 16;
    localparam int ADJ_W       = 8;
    localparam int OFF_W       = 24;
    localparam int PROD_W      = 25;
    localparam int FIELD_W     = 26;
    localparam int HEAD_W      = 15;
    localparam int CORD_W      = 45;
    localparam int ANG_W       = 34;
    localparam int CONV_W      = 49;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 96;

    // Vector pre-scale before rotation, and binary angle to 1/64 degree
    localparam int VEC_SHIFT   = 16;
    localparam int FRAC_SHIFT  = 32;
    localparam int DEG_SCALE   = 23040;
    localparam int GAIN_BIAS   = 128;
    localparam int ADJ_RESET   = 128;

    localparam int DEF_CORDIC_STAGES = 16;
    localparam int ATAN_N            = 32;

    localparam logic signed [ANG_W-1:0] HALF_TURN  = 34'sh0_8000_0000;
    localparam logic signed [CONV_W-1:0] ROUND_HALF = 49'sh0_0000_8000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADJ_X,
        REG_ADJ_Y,
        REG_ADJ_Z,
        REG_OFF_X,
        REG_OFF_Y,
        REG_OFF_Z
    } t_reg_idx;

    typedef logic signed [FIELD_W-1:0] t_field;

    typedef struct packed {
        t_field fx;
        t_field fy;
        t_field fz;
    } t_fields;

    // One CORDIC slot: vector, accumulated angle, zero-vector flag
    typedef struct packed {
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic signed [ANG_W-1:0]  z;
        logic                     zero;
    } t_cordic;

    // atan(2^-i) in binary angle units, 2^32 per turn
    localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

[hdl/magnetometer_adjust_heading_core.sv]
// Top level: magnetometer gain/offset correction and CORDIC heading pipeline.
//
//  port group   dir  tdata fields (lowest bit first)
//  s_axis       in   raw_x[15:0], raw_y[31:16], raw_z[47:32]
//  m_axis       out  field_x[25:0], field_y[51:26], field_z[77:52], heading[92:78]
//  cfg          in   i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// One request enters per cycle while the output is not stalled. The stages are
// the multiply, offset, pre-rotation, one stage per CORDIC rotation, and the
// two-stage angle conversion. Each stage has a valid bit and holds only when
// it is full and the stage after it holds, so bubbles close up under stalls.
// Synchronous active-low reset clears valid bits and offsets and sets the adjust registers to 128.
module magnetometer_adjust_heading_core #(
    parameter int CORDIC_STAGES = mah_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // raw_x, raw_y, raw_z
    input  logic [mah_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // field_x, field_y, field_z, heading, zero fill
    output logic [mah_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [mah_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mah_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import mah_pkg::*;

    localparam int ST_PRE   = 2;
    localparam int ST_CORD0 = 3;
    localparam int ST_CMUL  = ST_CORD0 + CORDIC_STAGES;
    localparam int ST_OUT   = ST_CMUL + 1;
    localparam int NST      = ST_OUT + 1;
    localparam int DLY      = NST - ST_PRE;

    logic [ADJ_W-1:0]        r_adj_x, r_adj_y, r_adj_z;
    logic signed [OFF_W-1:0] r_off_x, r_off_y, r_off_z;

    logic [NST-1:0]          r_vld;
    logic [NST:0]            w_en;

    t_fields                 w_fld;
    t_fields                 r_dly [DLY];
    t_cordic                 n_pre;
    t_cordic                 r_pre;
    t_cordic                 w_cord [CORDIC_STAGES+1];
    logic signed [HEAD_W-1:0] w_head;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_x <= ADJ_W'(ADJ_RESET);
            r_adj_y <= ADJ_W'(ADJ_RESET);
            r_adj_z <= ADJ_W'(ADJ_RESET);
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ADJ_X: r_adj_x <= i_cfg_data[ADJ_W-1:0];
                REG_ADJ_Y: r_adj_y <= i_cfg_data[ADJ_W-1:0];
                REG_ADJ_Z: r_adj_z <= i_cfg_data[ADJ_W-1:0];
                REG_OFF_X: r_off_x <= $signed(i_cfg_data[OFF_W-1:0]);
                REG_OFF_Y: r_off_y <= $signed(i_cfg_data[OFF_W-1:0]);
                REG_OFF_Z: r_off_z <= $signed(i_cfg_data[OFF_W-1:0]);
                default: ;
            endcase
        end
    end

    // Stage enables: advance when empty or when the next stage advances
    always_comb begin
        w_en[NST] = i_m_axis_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_axis_tvalid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // Per-axis correction, stages 0 and 1
    mah_axis_scale u_scale_x (
        .i_clk    (i_clk),
        .i_en_mul (w_en[0]),
        .i_en_add (w_en[1]),
        .i_raw    ($signed(i_s_axis_tdata[RAW_W-1:0])),
        .i_adj    (r_adj_x),
        .i_off    (r_off_x),
        .o_field  (w_fld.fx)
    );

    mah_axis_scale u_scale_y (
        .i_clk    (i_clk),
        .i_en_mul (w_en[0]),
        .i_en_add (w_en[1]),
        .i_raw    ($signed(i_s_axis_tdata[2*RAW_W-1:RAW_W])),
        .i_adj    (r_adj_y),
        .i_off    (r_off_y),
        .o_field  (w_fld.fy)
    );

    mah_axis_scale u_scale_z (
        .i_clk    (i_clk),
        .i_en_mul (w_en[0]),
        .i_en_add (w_en[1]),
        .i_raw    ($signed(i_s_axis_tdata[3*RAW_W-1:2*RAW_W])),
        .i_adj    (r_adj_z),
        .i_off    (r_off_z),
        .o_field  (w_fld.fz)
    );

    // Carry corrected fields alongside the heading pipeline
    for (genvar k = 0; k < DLY; k++) begin : g_dly
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en[ST_PRE]) begin
                    r_dly[0] <= w_fld;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_en[ST_PRE+k]) begin
                    r_dly[k] <= r_dly[k-1];
                end
            end
        end
    end

    // Pre-rotation: start from (y, x) and fold the left half plane
    always_comb begin
        n_pre.zero = (w_fld.fx == '0) && (w_fld.fy == '0);
        n_pre.cx   = {{(CORD_W-FIELD_W-VEC_SHIFT){w_fld.fy[FIELD_W-1]}}, w_fld.fy,
                      {VEC_SHIFT{1'b0}}};
        n_pre.cy   = {{(CORD_W-FIELD_W-VEC_SHIFT){w_fld.fx[FIELD_W-1]}}, w_fld.fx,
                      {VEC_SHIFT{1'b0}}};
        n_pre.z    = '0;
        if (w_fld.fy < 0) begin
            n_pre.z  = (w_fld.fx >= 0) ? HALF_TURN : -HALF_TURN;
            n_pre.cx = -n_pre.cx;
            n_pre.cy = -n_pre.cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PRE]) begin
            r_pre <= n_pre;
        end
    end

    // Rotation chain, one register stage per iteration
    assign w_cord[0] = r_pre;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cord
        mah_cordic_stage #(
            .SHIFT (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_en    (w_en[ST_CORD0+i]),
            .i_stage (w_cord[i]),
            .o_stage (w_cord[i+1])
        );
    end

    mah_heading_conv u_conv (
        .i_clk     (i_clk),
        .i_en_mul  (w_en[ST_CMUL]),
        .i_en_out  (w_en[ST_OUT]),
        .i_stage   (w_cord[CORDIC_STAGES]),
        .o_heading (w_head)
    );

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = OUT_DATA_W'({w_head, r_dly[DLY-1].fz, r_dly[DLY-1].fy,
                                          r_dly[DLY-1].fx});

    // A ready sink lets the whole pipeline take a request
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input not ready while output is ready");

    // Heading stays within a half turn either way
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_head >= -15'sd11520) && (w_head <= 15'sd11520))
        else $error("heading out of range");

    // Zero vector gives zero heading
    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_dly[DLY-1].fx == '0) && (r_dly[DLY-1].fy == '0))
            |-> (w_head == '0))
        else $error("nonzero heading for zero vector");

endmodule

[hdl/mah_axis_scale.sv]
// One axis: sensitivity multiply stage followed by offset add stage.
module mah_axis_scale (
    input  logic                                 i_clk,
    input  logic                                 i_en_mul,
    input  logic                                 i_en_add,
    input  logic signed [mah_pkg::RAW_W-1:0]     i_raw,
    input  logic        [mah_pkg::ADJ_W-1:0]     i_adj,
    input  logic signed [mah_pkg::OFF_W-1:0]     i_off,
    output mah_pkg::t_field                      o_field
);
    import mah_pkg::*;

    logic        [ADJ_W:0]    w_gain;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    t_field                   n_field;
    t_field                   r_field;

    // Gain is adj + 128, always positive
    assign w_gain  = {1'b0, i_adj} + (ADJ_W+1)'(GAIN_BIAS);
    assign n_prod  = PROD_W'(i_raw) * $signed({{(PROD_W-ADJ_W-1){1'b0}}, w_gain});
    assign n_field = FIELD_W'(r_prod) + FIELD_W'(i_off);

    // Advance multiply stage
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod <= n_prod;
        end
    end

    // Advance offset stage
    always_ff @(posedge i_clk) begin
        if (i_en_add) begin
            r_field <= n_field;
        end
    end

    assign o_field = r_field;

endmodule

[hdl/mah_cordic_stage.sv]
// One registered CORDIC vectoring rotation with a fixed shift.
module mah_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  mah_pkg::t_cordic i_stage,
    output mah_pkg::t_cordic o_stage
);
    import mah_pkg::*;

    logic signed [CORD_W-1:0] w_sx;
    logic signed [CORD_W-1:0] w_sy;
    logic signed [ANG_W-1:0]  w_ang;
    t_cordic                  n_stage;
    t_cordic                  r_stage;

    assign w_sx  = i_stage.cx >>> SHIFT;
    assign w_sy  = i_stage.cy >>> SHIFT;
    assign w_ang = $signed({{(ANG_W-32){1'b0}}, ATAN_TAB[SHIFT]});

    // Rotate toward the x axis
    always_comb begin
        n_stage.zero = i_stage.zero;
        if (i_stage.cy > 0) begin
            n_stage.cx = i_stage.cx + w_sy;
            n_stage.cy = i_stage.cy - w_sx;
            n_stage.z  = i_stage.z + w_ang;
        end else begin
            n_stage.cx = i_stage.cx - w_sy;
            n_stage.cy = i_stage.cy + w_sx;
            n_stage.z  = i_stage.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[hdl/mah_heading_conv.sv]
// Binary angle to 1/64 degree: scale multiply stage, then round stage.
module mah_heading_conv (
    input  logic                                i_clk,
    input  logic                                i_en_mul,
    input  logic                                i_en_out,
    input  mah_pkg::t_cordic                    i_stage,
    output logic signed [mah_pkg::HEAD_W-1:0]   o_heading
);
    import mah_pkg::*;

    logic signed [CONV_W-1:0] n_prod;
    logic signed [CONV_W-1:0] r_prod;
    logic                     r_zero;
    logic signed [CONV_W-1:0] w_sum;
    logic signed [HEAD_W-1:0] n_head;
    logic signed [HEAD_W-1:0] r_head;

    assign n_prod = CONV_W'(i_stage.z) * $signed(CONV_W'(DEG_SCALE));

    // Round to nearest, halves up; zero vector reads as zero
    assign w_sum  = r_prod + ROUND_HALF;
    assign n_head = r_zero ? '0 : $signed(w_sum[FRAC_SHIFT +: HEAD_W]);

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod <= n_prod;
            r_zero <= i_stage.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_head <= n_head;
        end
    end

    assign o_heading = r_head;

endmodule

[bench/magnetometer_adjust_heading_core_tb.sv]
// Testbench for the magnetometer gain/offset correction and CORDIC heading core.
module magnetometer_adjust_heading_core_tb;

    import mah_pkg::*;

    localparam int STAGES   = DEF_CORDIC_STAGES;
    localparam int LATENCY  = STAGES + 5;
    localparam int IDLE_PCT = 25;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 125;

    // Register indexes past the last register: writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        t_field                   fx;
        t_field                   fy;
        t_field                   fz;
        logic signed [HEAD_W-1:0] heading;
    } t_compass_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the configuration registers
    logic [ADJ_W-1:0]        adj_x = ADJ_W'(ADJ_RESET);
    logic [ADJ_W-1:0]        adj_y = ADJ_W'(ADJ_RESET);
    logic [ADJ_W-1:0]        adj_z = ADJ_W'(ADJ_RESET);
    logic signed [OFF_W-1:0] off_x = '0;
    logic signed [OFF_W-1:0] off_y = '0;
    logic signed [OFF_W-1:0] off_z = '0;

    t_compass_result pending_fields[$];
    int              mismatch_count = 0;
    bit              steady_flow = 1'b0;

    magnetometer_adjust_heading_core #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Angle of (fx, fy) from the Y axis, worked in binary angles with 2^32 per turn, returned in 1/64 degree
    function automatic logic signed [HEAD_W-1:0] cordic_heading(longint fx, longint fy);
        longint cx;
        longint cy;
        longint nx;
        longint ny;
        longint ang;
        if (fx == 0 && fy == 0)
            return '0;
        cx  = fy * (longint'(1) << VEC_SHIFT);
        cy  = fx * (longint'(1) << VEC_SHIFT);
        ang = 0;
        // fold the left half plane onto the right one
        if (cx < 0) begin
            ang = (cy >= 0) ? 64'sh8000_0000 : -64'sh8000_0000;
            cx  = -cx;
            cy  = -cy;
        end
        for (int i = 0; i < STAGES && i < ATAN_N; i++) begin
            if (cy > 0) begin
                nx  = cx + (cy >>> i);
                ny  = cy - (cx >>> i);
                ang = ang + longint'(ATAN_TAB[i]);
            end else begin
                nx  = cx - (cy >>> i);
                ny  = cy + (cx >>> i);
                ang = ang - longint'(ATAN_TAB[i]);
            end
            cx = nx;
            cy = ny;
        end
        // round to nearest 1/64 degree, halves up
        ang = (ang * DEG_SCALE + 64'sh8000_0000) >>> FRAC_SHIFT;
        return ang[HEAD_W-1:0];
    endfunction

    // Corrected axes plus offsets, and the heading of the corrected x/y pair
    function automatic t_compass_result predict_compass(logic signed [RAW_W-1:0] rx,
                                                        logic signed [RAW_W-1:0] ry,
                                                        logic signed [RAW_W-1:0] rz);
        t_compass_result res;
        longint          fx;
        longint          fy;
        longint          fz;
        fx = longint'(rx) * (longint'(adj_x) + GAIN_BIAS) + longint'(off_x);
        fy = longint'(ry) * (longint'(adj_y) + GAIN_BIAS) + longint'(off_y);
        fz = longint'(rz) * (longint'(adj_z) + GAIN_BIAS) + longint'(off_z);
        res.fx      = fx[FIELD_W-1:0];
        res.fy      = fy[FIELD_W-1:0];
        res.fz      = fz[FIELD_W-1:0];
        res.heading = cordic_heading(fx, fy);
        return res;
    endfunction

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ADJ_X: adj_x = val[ADJ_W-1:0];
            REG_ADJ_Y: adj_y = val[ADJ_W-1:0];
            REG_ADJ_Z: adj_z = val[ADJ_W-1:0];
            REG_OFF_X: off_x = val;
            REG_OFF_Y: off_y = val;
            REG_OFF_Z: off_z = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [ADJ_W-1:0] ax, input logic [ADJ_W-1:0] ay,
                             input logic [ADJ_W-1:0] az, input logic [OFF_W-1:0] ox,
                             input logic [OFF_W-1:0] oy, input logic [OFF_W-1:0] oz);
        write_reg(REG_ADJ_X, {16'h0, ax});
        write_reg(REG_ADJ_Y, {16'h0, ay});
        write_reg(REG_ADJ_Z, {16'h0, az});
        write_reg(REG_OFF_X, ox);
        write_reg(REG_OFF_Y, oy);
        write_reg(REG_OFF_Z, oz);
    endtask

    // Offer one request, idling at random first; record its prediction on acceptance
    task automatic send_sample(input logic signed [RAW_W-1:0] rx,
                               input logic signed [RAW_W-1:0] ry,
                               input logic signed [RAW_W-1:0] rz);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tdata  <= {rz, ry, rx};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_fields.push_back(predict_compass(rx, ry, rz));
    endtask

    // Drop valid and wait until every request has come back
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [RAW_W-1:0] pick_raw();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return RAW_W'($urandom_range(8) - 4);
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [ADJ_W-1:0] pick_adj();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd255;
            2: return ADJ_W'(ADJ_RESET);
            default: return ADJ_W'($urandom);
        endcase
    endfunction

    function automatic logic [OFF_W-1:0] pick_off();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return '0;
            3: return OFF_W'($urandom_range(2000) - 1000);
            default: return OFF_W'($urandom);
        endcase
    endfunction

    // Axes, quadrants and extremes at the reset gain
    task automatic test_default_gain;
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd1000, 16'sd5);
        send_sample(16'sd1000, 16'sd0, -16'sd5);
        send_sample(16'sd0, -16'sd1000, 16'sd0);
        send_sample(-16'sd1000, 16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sd1, 16'sh8000, 16'sd0);
        send_sample(-16'sd1, 16'sh8000, 16'sd0);
        send_sample(16'sh7FFF, -16'sd1, 16'sh8000);
        send_sample(16'sd3, -16'sd4, 16'sd1);
        drain();
    endtask

    // Gain and offset extremes, wide write values, spare indexes, offset-cancelled vector
    task automatic test_register_extremes;
        write_all(8'd0, 8'd0, 8'd0, 24'h800000, 24'h800000, 24'h800000);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        drain();
        // upper bits of an adjust write are ignored
        write_reg(REG_ADJ_X, 24'h5A5AFF);
        write_reg(REG_ADJ_Y, 24'hA5A5FF);
        write_reg(REG_ADJ_Z, 24'hFFFFFF);
        write_reg(REG_OFF_X, 24'h7FFFFF);
        write_reg(REG_OFF_Y, 24'h7FFFFF);
        write_reg(REG_OFF_Z, 24'h7FFFFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF, 16'sd0);
        drain();
        write_reg(CFG_IDX_SPARE_LO, 24'hFFFFFF);
        write_reg(CFG_IDX_SPARE_HI, 24'h000000);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        drain();
        // offsets that cancel the corrected x/y exactly
        write_all(ADJ_W'(ADJ_RESET), ADJ_W'(ADJ_RESET), ADJ_W'(ADJ_RESET),
                  -24'sd25600, 24'sd51200, 24'sd0);
        send_sample(16'sd100, -16'sd200, 16'sd0);
        send_sample(16'sd100, -16'sd199, 16'sd0);
        send_sample(16'sd99, -16'sd200, 16'sd0);
        drain();
    endtask

    // Random settings per phase; the first phase runs without idling
    task automatic test_random_phases;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_all(pick_adj(), pick_adj(), pick_adj(), pick_off(), pick_off(), pick_off());
            steady_flow = (ph == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(pick_raw(), pick_raw(), pick_raw());
            drain();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_gain();
        test_register_extremes();
        test_random_phases();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (pending_fields.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_fields.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Stall the result side at random and check each accepted result
    always @(posedge i_clk) begin
        t_compass_result exp_res;
        t_compass_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.fx      = o_m_axis_tdata[FIELD_W-1:0];
            got.fy      = o_m_axis_tdata[2*FIELD_W-1:FIELD_W];
            got.fz      = o_m_axis_tdata[3*FIELD_W-1:2*FIELD_W];
            got.heading = o_m_axis_tdata[3*FIELD_W+HEAD_W-1:3*FIELD_W];
            if (pending_fields.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time,
                         o_m_axis_tdata);
                mismatch_count++;
            end else begin
                exp_res = pending_fields.pop_front();
                if (got.fx !== exp_res.fx) begin
                    $display("%0t: field_x expected %0d got %0d", $time, exp_res.fx, got.fx);
                    mismatch_count++;
                end
                if (got.fy !== exp_res.fy) begin
                    $display("%0t: field_y expected %0d got %0d", $time, exp_res.fy, got.fy);
                    mismatch_count++;
                end
                if (got.fz !== exp_res.fz) begin
                    $display("%0t: field_z expected %0d got %0d", $time, exp_res.fz, got.fz);
                    mismatch_count++;
                end
                if (got.heading !== exp_res.heading) begin
                    $display("%0t: heading expected %0d got %0d", $time,
                             exp_res.heading, got.heading);
                    mismatch_count++;
                end
            end
        end
        i_m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // Hard stop if the run hangs
    initial begin
        #(200_000 * 12);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
hdl/mah_pkg.sv
hdl/mah_axis_scale.sv
hdl/mah_cordic_stage.sv
hdl/mah_heading_conv.sv
hdl/magnetometer_adjust_heading_core.sv
bench/magnetometer_adjust_heading_core_tb.sv
